FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define ASSERT_IMPLIES(name, ant, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(name, ant, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_IMPLIES(name, ant, cons, msg)
`define ASSERT_NEXT(name, ant, cons, msg)

`endif

`endif

FILE: src/m4i_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4i_pkg
// Shared types, constants and index tables of the 4x4 matrix inverse.
// ----------------------------------------------------------------------------
package m4i_pkg;

    // Multiplier digit width of the shared multiply-accumulate unit.
    localparam int DIGIT_WIDTH = 16;

    typedef struct packed {
        logic load;
        logic clear;
        logic neg;
        logic step;
    } mac_ctrl_t;

    typedef struct packed {
        logic load;
        logic check;
        logic step;
    } div_ctrl_t;

    // 2x2 minor n = m[a]*m[b] - m[c]*m[d], packed as {a, b, c, d}.
    // Minors 0..5 use rows 0,1; minors 6..11 use rows 2,3.
    function automatic logic [15:0] minor_sel(input logic [3:0] n);
        logic [15:0] r;
        unique case (n)
            4'd0:    r = {4'd0,  4'd5,  4'd4,  4'd1};
            4'd1:    r = {4'd0,  4'd6,  4'd4,  4'd2};
            4'd2:    r = {4'd0,  4'd7,  4'd4,  4'd3};
            4'd3:    r = {4'd1,  4'd6,  4'd5,  4'd2};
            4'd4:    r = {4'd1,  4'd7,  4'd5,  4'd3};
            4'd5:    r = {4'd2,  4'd7,  4'd6,  4'd3};
            4'd6:    r = {4'd8,  4'd13, 4'd12, 4'd9};
            4'd7:    r = {4'd8,  4'd14, 4'd12, 4'd10};
            4'd8:    r = {4'd8,  4'd15, 4'd12, 4'd11};
            4'd9:    r = {4'd9,  4'd14, 4'd13, 4'd10};
            4'd10:   r = {4'd9,  4'd15, 4'd13, 4'd11};
            4'd11:   r = {4'd10, 4'd15, 4'd14, 4'd11};
            default: r = '0;
        endcase
        return r;
    endfunction

    // Matrix element of cofactor term t for adjugate entry k.
    function automatic logic [3:0] adj_m_idx(input logic [3:0] k, input logic [1:0] t);
        logic [11:0] r;
        unique case (k)
            4'd0:    r = {4'd5,  4'd6,  4'd7};
            4'd1:    r = {4'd1,  4'd2,  4'd3};
            4'd2:    r = {4'd13, 4'd14, 4'd15};
            4'd3:    r = {4'd9,  4'd10, 4'd11};
            4'd4:    r = {4'd4,  4'd6,  4'd7};
            4'd5:    r = {4'd0,  4'd2,  4'd3};
            4'd6:    r = {4'd12, 4'd14, 4'd15};
            4'd7:    r = {4'd8,  4'd10, 4'd11};
            4'd8:    r = {4'd4,  4'd5,  4'd7};
            4'd9:    r = {4'd0,  4'd1,  4'd3};
            4'd10:   r = {4'd12, 4'd13, 4'd15};
            4'd11:   r = {4'd8,  4'd9,  4'd11};
            4'd12:   r = {4'd4,  4'd5,  4'd6};
            4'd13:   r = {4'd0,  4'd1,  4'd2};
            4'd14:   r = {4'd12, 4'd13, 4'd14};
            default: r = {4'd8,  4'd9,  4'd10};
        endcase
        unique case (t)
            2'd0:    return r[11:8];
            2'd1:    return r[7:4];
            default: return r[3:0];
        endcase
    endfunction

    // Minor number (0..5) of cofactor term t, by k[3:2], the matrix column that the cofactor excludes.
    function automatic logic [2:0] adj_x_idx(input logic [1:0] col, input logic [1:0] t);
        logic [8:0] r;
        unique case (col)
            2'd0:    r = {3'd5, 3'd4, 3'd3};
            2'd1:    r = {3'd5, 3'd2, 3'd1};
            2'd2:    r = {3'd4, 3'd2, 3'd0};
            default: r = {3'd3, 3'd1, 3'd0};
        endcase
        unique case (t)
            2'd0:    return r[8:6];
            2'd1:    return r[5:3];
            default: return r[2:0];
        endcase
    endfunction

endpackage

FILE: src/m4i_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4i_elem_if / m4i_res_if
// Valid/ready channels for matrix elements and inverse results.
// ----------------------------------------------------------------------------
interface m4i_elem_if #(parameter int W = 32) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] element;

    modport source (output valid, output element, input ready);
    modport sink (input valid, input element, output ready);
endinterface

interface m4i_res_if #(parameter int W = 32) ();
    logic                valid;
    logic                ready;
    logic signed [W-1:0] result_element;
    logic                singular;
    logic                saturated;
    logic                last;

    modport source (output valid, output result_element, output singular,
                    output saturated, output last, input ready);
    modport sink (input valid, input result_element, input singular,
                  input saturated, input last, output ready);
endinterface

FILE: src/m4i_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4i_store
// Sixteen-entry element memory, one write port, two registered read ports.
// ----------------------------------------------------------------------------
module m4i_store #(
    parameter int W = 32
) (
    input  logic                clk,
    input  logic                we,
    input  logic [3:0]          waddr,
    input  logic signed [W-1:0] wdata,
    input  logic                re,
    input  logic [3:0]          raddr_a,
    input  logic [3:0]          raddr_b,
    output logic signed [W-1:0] rdata_a,
    output logic signed [W-1:0] rdata_b
);

    logic signed [W-1:0] mem [16];
    logic signed [W-1:0] rdata_a_reg;
    logic signed [W-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

FILE: src/m4i_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4i_mac
// Shared multiply-accumulate unit: sign-magnitude product, one multiplier
// digit per step cycle, added with its sign into a wide accumulator.
// ----------------------------------------------------------------------------
module m4i_mac import m4i_pkg::*; #(
    parameter int OPW = 65,
    parameter int ACW = 131
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  mac_ctrl_t             ctrl,
    input  logic signed [OPW-1:0] a,
    input  logic signed [OPW-1:0] b,
    output logic signed [ACW-1:0] acc,
    output logic                  last_digit
);

    localparam int ND  = (OPW + DIGIT_WIDTH - 1) / DIGIT_WIDTH;
    localparam int NDW = ND * DIGIT_WIDTH;
    localparam int DCW = $clog2(ND);

    logic [OPW-1:0]             ma_reg;
    logic [NDW-1:0]             mb_reg;
    logic                       neg_reg;
    logic [DCW-1:0]             dig_reg;
    logic [DCW-1:0]             dig_next;
    logic signed [ACW-1:0]      acc_reg;

    logic [OPW-1:0]             mag_a;
    logic [OPW-1:0]             mag_b;
    logic [OPW+DIGIT_WIDTH-1:0] prod;
    logic [ACW-1:0]             part;
    logic [ACW-1:0]             term;

    assign mag_a = a[OPW-1] ? (~a + 1'b1) : a;
    assign mag_b = b[OPW-1] ? (~b + 1'b1) : b;

    assign prod = ma_reg * mb_reg[DIGIT_WIDTH-1:0];
    assign part = ACW'(prod) << (int'(dig_reg) * DIGIT_WIDTH);
    assign term = neg_reg ? (~part + 1'b1) : part;

    always_comb
    begin
        dig_next = dig_reg;
        if (ctrl.load)
        begin
            dig_next = '0;
        end
        else if (ctrl.step)
        begin
            dig_next = dig_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dig_reg <= '0;
        end
        else
        begin
            dig_reg <= dig_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            ma_reg  <= mag_a;
            mb_reg  <= NDW'(mag_b);
            neg_reg <= a[OPW-1] ^ b[OPW-1] ^ ctrl.neg;
            if (ctrl.clear)
            begin
                acc_reg <= '0;
            end
        end
        else if (ctrl.step)
        begin
            acc_reg <= acc_reg + $signed(term);
            mb_reg  <= mb_reg >> DIGIT_WIDTH;
        end
    end

    assign acc        = acc_reg;
    assign last_digit = (dig_reg == DCW'(ND - 1));

endmodule

FILE: src/m4i_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// m4i_div
// Restoring divider, one quotient bit per step cycle: |adj| * 2^(2F) / |det|.
// An overflow check ahead of the steps flags quotients of 2^E and above.
// ----------------------------------------------------------------------------
module m4i_div import m4i_pkg::*; #(
    parameter int E  = 32,
    parameter int F  = 16,
    parameter int AW = 98,
    parameter int DW = 131
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  div_ctrl_t            ctrl,
    input  logic signed [AW-1:0] adj,
    input  logic [DW-1:0]        dmag,
    output logic [E-1:0]         quot,
    output logic                 big,
    output logic                 last_step
);

    localparam int NW  = AW + 2 * F;
    localparam int RW  = (DW + 1 > NW - E) ? DW + 1 : NW - E;
    localparam int CW  = $clog2(E);

    logic [RW-1:0] rem_reg;
    logic [E-1:0]  nlo_reg;
    logic [E-1:0]  quot_reg;
    logic          big_reg;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;

    logic [AW-1:0] mag;
    logic [NW-1:0] num;
    logic [RW-1:0] dext;
    logic [RW-1:0] rs;
    logic          ge;

    assign mag  = adj[AW-1] ? (~adj + 1'b1) : adj;
    assign num  = {mag, {(2 * F){1'b0}}};
    assign dext = RW'(dmag);
    assign rs   = {rem_reg[RW-2:0], nlo_reg[E-1]};
    assign ge   = (rs >= dext);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctrl.load)
        begin
            cnt_next = '0;
        end
        else if (ctrl.step)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            rem_reg  <= RW'(num[NW-1:E]);
            nlo_reg  <= num[E-1:0];
            quot_reg <= '0;
        end
        else if (ctrl.check)
        begin
            // floor(num / 2^E) >= d  <=>  quotient >= 2^E
            big_reg <= (rem_reg >= dext);
        end
        else if (ctrl.step)
        begin
            rem_reg  <= ge ? (rs - dext) : rs;
            nlo_reg  <= nlo_reg << 1;
            quot_reg <= {quot_reg[E-2:0], ge};
        end
    end

    assign quot      = quot_reg;
    assign big       = big_reg;
    assign last_step = (cnt_reg == CW'(E - 1));

endmodule

FILE: src/matrix4x4_inverse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix4x4_inverse
// Flow: 16 element loads, then 24 minor terms and 6 determinant terms, each
// a fetch, a MAC load, ND = ceil((2E+1)/16) multiplier digits (5 at E=32),
// plus 13 writebacks; each result then takes 3 terms, a writeback, the
// overflow check and bit-serial divider steps, a clip and the output.
// Singular matrix: each result reads back the input element, flagged singular.
// One matrix at a time, not ready meanwhile. rst_n clears sequencer, counts.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module matrix4x4_inverse import m4i_pkg::*; #(
    parameter int ELEMENT_WIDTH = 32,
    parameter int FRACTION_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    m4i_elem_if.sink      matrix,
    m4i_res_if.source     inverse
);

    localparam int E  = ELEMENT_WIDTH;
    localparam int MW = 2 * E + 1;
    localparam int AW = 3 * E + 2;
    localparam int DW = 4 * E + 3;

    typedef enum logic [10:0] {
        S_LOAD  = 11'b00000000001,
        S_FETCH = 11'b00000000010,
        S_PREP  = 11'b00000000100,
        S_MUL   = 11'b00000001000,
        S_WB    = 11'b00000010000,
        S_DCHK  = 11'b00000100000,
        S_DIV   = 11'b00001000000,
        S_FIN   = 11'b00010000000,
        S_SRD   = 11'b00100000000,
        S_SLD   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } state_t;

    typedef enum logic [2:0] {
        PH_MINOR = 3'b001,
        PH_DET   = 3'b010,
        PH_ADJ   = 3'b100
    } phase_t;

    state_t              state_reg, state_next;
    phase_t              phase_reg, phase_next;
    logic [3:0]          load_cnt_reg, load_cnt_next;
    logic [3:0]          grp_reg, grp_next;
    logic [2:0]          term_reg, term_next;

    logic signed [MW-1:0] s_reg [6];
    logic signed [MW-1:0] c_reg [6];
    logic [DW-1:0]        dmag_reg;
    logic                 det_neg_reg;
    logic                 qneg_reg;

    logic signed [E-1:0]  out_elem_reg;
    logic                 out_sing_reg;
    logic                 out_sat_reg;
    logic                 out_last_reg;

    logic                 in_fire;
    logic                 out_fire;

    logic [15:0]          msel;
    logic [3:0]           mi_a, mi_b;
    logic [3:0]           raddr_a;
    logic [2:0]           xi;
    logic [2:0]           s_idx, c_idx;
    logic signed [MW-1:0] s_rd, c_rd;
    logic signed [E-1:0]  rd_a, rd_b;
    logic                 mem_re;

    mac_ctrl_t            mac_ctrl;
    logic signed [MW-1:0] op_a, op_b;
    logic signed [DW-1:0] acc;
    logic                 last_digit;
    logic                 last_term;
    logic                 term_neg;

    div_ctrl_t            div_ctrl;
    logic [E-1:0]         quot;
    logic                 big;
    logic                 last_step;

    logic [E-1:0]         minneg;
    logic [E-1:0]         fin_res;
    logic                 fin_sat;

    assign in_fire  = matrix.valid && matrix.ready;
    assign out_fire = inverse.valid && inverse.ready;

    assign matrix.ready           = (state_reg == S_LOAD);
    assign inverse.valid          = (state_reg == S_OUT);
    assign inverse.result_element = out_elem_reg;
    assign inverse.singular       = out_sing_reg;
    assign inverse.saturated      = out_sat_reg;
    assign inverse.last           = out_last_reg;

    // ---- operand selection ----
    assign msel = minor_sel(grp_reg);
    assign mi_a = (term_reg == 3'd0) ? msel[15:12] : msel[7:4];
    assign mi_b = (term_reg == 3'd0) ? msel[11:8]  : msel[3:0];
    assign xi   = adj_x_idx(grp_reg[3:2], term_reg[1:0]);

    always_comb
    begin
        if (state_reg == S_SRD)
        begin
            raddr_a = grp_reg;
        end
        else if (phase_reg == PH_MINOR)
        begin
            raddr_a = mi_a;
        end
        else
        begin
            raddr_a = adj_m_idx(grp_reg, term_reg[1:0]);
        end
    end

    assign mem_re = (state_reg == S_FETCH) || (state_reg == S_SRD);

    assign s_idx = (phase_reg == PH_DET) ? term_reg : xi;
    assign c_idx = (phase_reg == PH_DET) ? (3'd5 - term_reg) : xi;
    assign s_rd  = s_reg[s_idx];
    assign c_rd  = c_reg[c_idx];

    always_comb
    begin
        unique case (phase_reg)
            PH_MINOR:
            begin
                op_a      = MW'(rd_a);
                op_b      = MW'(rd_b);
                term_neg  = (term_reg == 3'd1);
                last_term = (term_reg == 3'd1);
            end
            PH_DET:
            begin
                op_a      = s_rd;
                op_b      = c_rd;
                term_neg  = (term_reg == 3'd1) || (term_reg == 3'd4);
                last_term = (term_reg == 3'd5);
            end
            PH_ADJ:
            begin
                op_a      = MW'(rd_a);
                op_b      = grp_reg[1] ? s_rd : c_rd;
                term_neg  = (term_reg == 3'd1) ^ grp_reg[0] ^ grp_reg[2];
                last_term = (term_reg == 3'd2);
            end
            default:
            begin
                op_a      = '0;
                op_b      = '0;
                term_neg  = 1'b0;
                last_term = 1'b1;
            end
        endcase
    end

    assign mac_ctrl.load  = (state_reg == S_PREP);
    assign mac_ctrl.clear = (term_reg == 3'd0);
    assign mac_ctrl.neg   = term_neg;
    assign mac_ctrl.step  = (state_reg == S_MUL);

    assign div_ctrl.load  = (state_reg == S_WB) && (phase_reg == PH_ADJ);
    assign div_ctrl.check = (state_reg == S_DCHK);
    assign div_ctrl.step  = (state_reg == S_DIV);

    // ---- result sign and clipping ----
    assign minneg = {1'b1, {(E - 1){1'b0}}};

    always_comb
    begin
        fin_sat = 1'b0;
        fin_res = quot;
        if (big)
        begin
            fin_sat = 1'b1;
            fin_res = qneg_reg ? minneg : ~minneg;
        end
        else if (qneg_reg)
        begin
            if (quot > minneg)
            begin
                fin_sat = 1'b1;
                fin_res = minneg;
            end
            else
            begin
                fin_res = ~quot + 1'b1;
            end
        end
        else if (quot[E-1])
        begin
            fin_sat = 1'b1;
            fin_res = ~minneg;
        end
    end

    // ---- sequencer ----
    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        load_cnt_next = load_cnt_reg;
        grp_next      = grp_reg;
        term_next     = term_reg;
        unique case (state_reg)
            S_LOAD:
            begin
                if (in_fire)
                begin
                    load_cnt_next = load_cnt_reg + 1'b1;
                    if (load_cnt_reg == 4'd15)
                    begin
                        state_next = S_FETCH;
                        phase_next = PH_MINOR;
                        grp_next   = '0;
                        term_next  = '0;
                    end
                end
            end
            S_FETCH:
            begin
                state_next = S_PREP;
            end
            S_PREP:
            begin
                state_next = S_MUL;
            end
            S_MUL:
            begin
                if (last_digit)
                begin
                    if (last_term)
                    begin
                        state_next = S_WB;
                    end
                    else
                    begin
                        term_next  = term_reg + 1'b1;
                        state_next = S_FETCH;
                    end
                end
            end
            S_WB:
            begin
                term_next = '0;
                unique case (phase_reg)
                    PH_MINOR:
                    begin
                        state_next = S_FETCH;
                        if (grp_reg == 4'd11)
                        begin
                            phase_next = PH_DET;
                            grp_next   = '0;
                        end
                        else
                        begin
                            grp_next = grp_reg + 1'b1;
                        end
                    end
                    PH_DET:
                    begin
                        grp_next = '0;
                        if (acc == '0)
                        begin
                            state_next = S_SRD;
                        end
                        else
                        begin
                            phase_next = PH_ADJ;
                            state_next = S_FETCH;
                        end
                    end
                    default:
                    begin
                        state_next = S_DCHK;
                    end
                endcase
            end
            S_DCHK:
            begin
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (last_step)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_OUT;
            end
            S_SRD:
            begin
                state_next = S_SLD;
            end
            S_SLD:
            begin
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (out_fire)
                begin
                    if (grp_reg == 4'd15)
                    begin
                        state_next = S_LOAD;
                        grp_next   = '0;
                    end
                    else
                    begin
                        grp_next   = grp_reg + 1'b1;
                        state_next = out_sing_reg ? S_SRD : S_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            phase_reg    <= PH_MINOR;
            load_cnt_reg <= '0;
            grp_reg      <= '0;
            term_reg     <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            phase_reg    <= phase_next;
            load_cnt_reg <= load_cnt_next;
            grp_reg      <= grp_next;
            term_reg     <= term_next;
        end
    end

    // ---- datapath registers ----
    always_ff @(posedge clk)
    begin
        if (state_reg == S_WB)
        begin
            unique case (phase_reg)
                PH_MINOR:
                begin
                    if (grp_reg < 4'd6)
                    begin
                        s_reg[grp_reg[2:0]] <= acc[MW-1:0];
                    end
                    else
                    begin
                        c_reg[3'(grp_reg - 4'd6)] <= acc[MW-1:0];
                    end
                end
                PH_DET:
                begin
                    det_neg_reg <= acc[DW-1];
                    dmag_reg    <= acc[DW-1] ? (~acc + 1'b1) : acc;
                end
                default:
                begin
                    qneg_reg <= acc[AW-1] ^ det_neg_reg;
                end
            endcase
        end
        if (state_reg == S_FIN)
        begin
            out_elem_reg <= fin_res;
            out_sing_reg <= 1'b0;
            out_sat_reg  <= fin_sat;
            out_last_reg <= (grp_reg == 4'd15);
        end
        else if (state_reg == S_SLD)
        begin
            out_elem_reg <= rd_a;
            out_sing_reg <= 1'b1;
            out_sat_reg  <= 1'b0;
            out_last_reg <= (grp_reg == 4'd15);
        end
    end

    m4i_store #(
        .W (E)
    ) u_store (
        .clk     (clk),
        .we      (in_fire),
        .waddr   (load_cnt_reg),
        .wdata   (matrix.element),
        .re      (mem_re),
        .raddr_a (raddr_a),
        .raddr_b (mi_b),
        .rdata_a (rd_a),
        .rdata_b (rd_b)
    );

    m4i_mac #(
        .OPW (MW),
        .ACW (DW)
    ) u_mac (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (mac_ctrl),
        .a          (op_a),
        .b          (op_b),
        .acc        (acc),
        .last_digit (last_digit)
    );

    m4i_div #(
        .E  (E),
        .F  (FRACTION_BITS),
        .AW (AW),
        .DW (DW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .adj       (acc[AW-1:0]),
        .dmag      (dmag_reg),
        .quot      (quot),
        .big       (big),
        .last_step (last_step)
    );

    // ---- assertions ----
    `ASSERT_IMPLIES(a_last_on_final, inverse.valid,
        inverse.last == (grp_reg == 4'd15), "last flag does not match result index")
    `ASSERT_NEXT(a_ready_after_last, out_fire && inverse.last, matrix.ready,
        "not ready after last result")
    `ASSERT_NEXT(a_busy_after_load, in_fire && (load_cnt_reg == 4'd15), !matrix.ready,
        "ready while matrix in work")
    `ASSERT_IMPLIES(a_singular_unclipped, inverse.valid && inverse.singular,
        !inverse.saturated, "singular result flagged saturated")

endmodule
